### hdl/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper: decoder modes,
// character codes, UTF-8 lead and continuation marks, and the result record.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESCAPE = 3'd1,
      MODE_HEX0   = 3'd2,
      MODE_HEX1   = 3'd3,
      MODE_HEX2   = 3'd4,
      MODE_HEX3   = 3'd5
   } mode_type;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;

   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_FF  = 8'h0C;
   localparam logic [7:0] CTRL_LF  = 8'h0A;
   localparam logic [7:0] CTRL_CR  = 8'h0D;
   localparam logic [7:0] CTRL_TAB = 8'h09;

   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;
   localparam logic [15:0] CP_LIMIT1  = 16'h0080;
   localparam logic [15:0] CP_LIMIT2  = 16'h0800;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [1:0] out_count;
      logic       string_done;
      logic       error_flag;
   } result_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] acc;
   } state_type;

endpackage

### hdl/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Combinational decode of one string-body byte against the current decoder
// state: escape handling, hex digit gathering and UTF-8 encoding.
// ----------------------------------------------------------------------------
module jsu_decode (
   input  logic [7:0]          in_byte,
   input  jsu_pkg::state_type  state_cur,
   output jsu_pkg::state_type  state_nxt,
   output jsu_pkg::result_type result
);
   import jsu_pkg::*;

   logic [3:0]  hex_digit;
   logic [15:0] cp;

   // Anything that is not a hex digit counts as zero.
   always_comb begin
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_digit = 4'(in_byte - 8'h30);
      end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
         hex_digit = 4'(in_byte - 8'h57);
      end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
         hex_digit = 4'(in_byte - 8'h37);
      end else begin
         hex_digit = 4'd0;
      end
   end

   assign cp = {state_cur.acc[11:0], hex_digit};

   always_comb begin
      result    = '0;
      state_nxt = state_cur;
      if (in_byte == CHAR_NUL) begin
         result.error_flag = 1'b1;
         state_nxt.mode    = MODE_NORMAL;
         state_nxt.acc     = '0;
      end else begin
         case (state_cur.mode)
            MODE_ESCAPE: begin
               if (in_byte == CHAR_U) begin
                  state_nxt.mode = MODE_HEX0;
                  state_nxt.acc  = '0;
               end else begin
                  case (in_byte)
                     CHAR_B:  result.out_byte0 = CTRL_BS;
                     CHAR_F:  result.out_byte0 = CTRL_FF;
                     CHAR_N:  result.out_byte0 = CTRL_LF;
                     CHAR_R:  result.out_byte0 = CTRL_CR;
                     CHAR_T:  result.out_byte0 = CTRL_TAB;
                     default: result.out_byte0 = in_byte;
                  endcase
                  result.out_count = 2'd1;
                  state_nxt.mode   = MODE_NORMAL;
               end
            end
            MODE_HEX0: begin
               state_nxt.acc  = cp;
               state_nxt.mode = MODE_HEX1;
            end
            MODE_HEX1: begin
               state_nxt.acc  = cp;
               state_nxt.mode = MODE_HEX2;
            end
            MODE_HEX2: begin
               state_nxt.acc  = cp;
               state_nxt.mode = MODE_HEX3;
            end
            MODE_HEX3: begin
               if (cp < CP_LIMIT1) begin
                  result.out_byte0 = cp[7:0];
                  result.out_count = 2'd1;
               end else if (cp < CP_LIMIT2) begin
                  result.out_byte0 = UTF8_LEAD2 | {3'b000, cp[10:6]};
                  result.out_byte1 = UTF8_CONT | {2'b00, cp[5:0]};
                  result.out_count = 2'd2;
               end else begin
                  result.out_byte0 = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                  result.out_byte1 = UTF8_CONT | {2'b00, cp[11:6]};
                  result.out_byte2 = UTF8_CONT | {2'b00, cp[5:0]};
                  result.out_count = 2'd3;
               end
               state_nxt.mode = MODE_NORMAL;
               state_nxt.acc  = '0;
            end
            default: begin
               if (in_byte == CHAR_QUOTE) begin
                  result.string_done = 1'b1;
                  state_nxt.mode     = MODE_NORMAL;
                  state_nxt.acc      = '0;
               end else if (in_byte == CHAR_BACKSLASH) begin
                  state_nxt.mode = MODE_ESCAPE;
               end else begin
                  result.out_byte0 = in_byte;
                  result.out_count = 2'd1;
                  state_nxt.mode   = MODE_NORMAL;
               end
            end
         endcase
      end
   end

endmodule

### hdl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming JSON string-body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Feed the bytes of a JSON string body, starting just after the opening
// quote, one byte per req beat; every beat yields exactly one rsp beat with
// zero to three decoded bytes plus end-of-string and error flags. The block
// takes one beat per clock cycle while rsp does not hold it back. A beat
// passes through the input register and then the result register, with the
// decoder and its small mode/code-point state update between them.
// Backpressure on rsp stalls both stages; a new beat is still taken while a
// result waits if the input register is free.
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [1:0] rsp_out_count,
   output logic       rsp_string_done,
   output logic       rsp_error_flag
);
   import jsu_pkg::*;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type rsp_in;
   state_type  state_ff;
   state_type  state_in;
   logic       out_open;

   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_open;

   jsu_decode u_decode (
      .in_byte   (s1_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff.mode  <= MODE_NORMAL;
         state_ff.acc   <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_open) begin
            rsp_valid_ff <= s1_valid_ff;
            // The decoder state advances only when its beat moves on.
            if (s1_valid_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_in_byte;
      end
      if (out_open && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte0   = rsp_ff.out_byte0;
   assign rsp_out_byte1   = rsp_ff.out_byte1;
   assign rsp_out_byte2   = rsp_ff.out_byte2;
   assign rsp_out_count   = rsp_ff.out_count;
   assign rsp_string_done = rsp_ff.string_done;
   assign rsp_error_flag  = rsp_ff.error_flag;

endmodule

### tb/sv/tb_json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// Self-checking bench for the JSON string unescaper. Bytes of string bodies
// go in on req, one per beat. A behavioral decoder in the bench predicts each
// rsp beat, and every rsp beat is checked field by field against the oldest
// prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;
   import jsu_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 950;
   localparam int MAX_PRINTED = 40;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte0;
   logic [7:0] rsp_out_byte1;
   logic [7:0] rsp_out_byte2;
   logic [1:0] rsp_out_count;
   logic       rsp_string_done;
   logic       rsp_error_flag;

   // Decoder state kept by the bench.
   mode_type    esc_state = MODE_NORMAL;
   logic [15:0] uni_code = 16'h0000;

   result_type decoded_q[$];
   int         mismatch_count = 0;
   int         rsp_beats = 0;
   int         bytes_sent = 0;
   int         quiet_cycles = 0;
   bit         send_idle = 1'b1;
   bit         recv_idle = 1'b1;

   json_string_unescape_utf8 dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte0   (rsp_out_byte0),
      .rsp_out_byte1   (rsp_out_byte1),
      .rsp_out_byte2   (rsp_out_byte2),
      .rsp_out_count   (rsp_out_count),
      .rsp_string_done (rsp_string_done),
      .rsp_error_flag  (rsp_error_flag)
   );

   always #4 clock = ~clock;

   // Advances the bench decoder by one input byte and returns the result beat.
   function automatic result_type decode_byte(input logic [7:0] c);
      result_type  r;
      logic [3:0]  nib;
      logic [15:0] cp;
      r = '0;
      if (c == CHAR_NUL) begin
         r.error_flag = 1'b1;
         esc_state = MODE_NORMAL;
         uni_code = 16'h0000;
      end else begin
         case (esc_state)
            MODE_ESCAPE: begin
               if (c == CHAR_U) begin
                  esc_state = MODE_HEX0;
                  uni_code = 16'h0000;
               end else begin
                  case (c)
                     CHAR_B:  r.out_byte0 = CTRL_BS;
                     CHAR_F:  r.out_byte0 = CTRL_FF;
                     CHAR_N:  r.out_byte0 = CTRL_LF;
                     CHAR_R:  r.out_byte0 = CTRL_CR;
                     CHAR_T:  r.out_byte0 = CTRL_TAB;
                     default: r.out_byte0 = c;
                  endcase
                  r.out_count = 2'd1;
                  esc_state = MODE_NORMAL;
               end
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
               // Anything that is not a hex digit, quote and backslash included,
               // counts as a zero digit.
               if (c >= CHAR_0 && c <= CHAR_9) nib = 4'(c - CHAR_0);
               else if (c >= CHAR_LA && c <= CHAR_LF) nib = 4'(c - CHAR_LA + 8'd10);
               else if (c >= CHAR_UA && c <= CHAR_UF) nib = 4'(c - CHAR_UA + 8'd10);
               else nib = 4'h0;
               cp = {uni_code[11:0], nib};
               if (esc_state == MODE_HEX3) begin
                  if (cp < CP_LIMIT1) begin
                     r.out_byte0 = cp[7:0];
                     r.out_count = 2'd1;
                  end else if (cp < CP_LIMIT2) begin
                     r.out_byte0 = UTF8_LEAD2 | {3'b000, cp[10:6]};
                     r.out_byte1 = UTF8_CONT | {2'b00, cp[5:0]};
                     r.out_count = 2'd2;
                  end else begin
                     r.out_byte0 = UTF8_LEAD3 | {4'h0, cp[15:12]};
                     r.out_byte1 = UTF8_CONT | {2'b00, cp[11:6]};
                     r.out_byte2 = UTF8_CONT | {2'b00, cp[5:0]};
                     r.out_count = 2'd3;
                  end
                  esc_state = MODE_NORMAL;
                  uni_code = 16'h0000;
               end else begin
                  uni_code = cp;
                  esc_state = mode_type'(esc_state + 3'd1);
               end
            end
            default: begin
               if (c == CHAR_QUOTE) begin
                  r.string_done = 1'b1;
                  esc_state = MODE_NORMAL;
                  uni_code = 16'h0000;
               end else if (c == CHAR_BACKSLASH) begin
                  esc_state = MODE_ESCAPE;
               end else begin
                  r.out_byte0 = c;
                  r.out_count = 2'd1;
                  esc_state = MODE_NORMAL;
               end
            end
         endcase
      end
      return r;
   endfunction

   // One draw in four gives no wait, and none waits when on is low, so that back-to-back beats occur often.
   function automatic int draw_wait(input bit on);
      if (!on) return 0;
      case ($urandom_range(0, 3))
         0, 1:    return $urandom_range(0, 17);
         2:       return $urandom_range(0, 2);
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("mismatch at rsp beat %0d: %s", rsp_beats, msg);
   endtask

   // Valid is lowered only when a gap is drawn, so consecutive beats keep it high.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_wait(send_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      decoded_q.push_back(decode_byte(b));
      bytes_sent++;
   endtask

   // Sends backslash, u and four digits of cp in random case. A bad digit
   // replaces digit bad_pos; a zero byte replaces digit cut_at and ends it.
   task automatic send_unicode(input logic [15:0] cp, input int bad_pos, input int cut_at);
      logic [3:0] nib;
      logic [7:0] ch;
      send_byte(CHAR_BACKSLASH);
      send_byte(CHAR_U);
      for (int i = 0; i < 4; i++) begin
         nib = cp[15 - 4 * i -: 4];
         if (nib < 4'd10) ch = CHAR_0 + {4'h0, nib};
         else ch = ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + {4'h0, nib} - 8'd10;
         if (i == bad_pos) begin
            do ch = 8'($urandom_range(1, 255));
            while ((ch >= CHAR_0 && ch <= CHAR_9) || (ch >= CHAR_LA && ch <= CHAR_LF) ||
                   (ch >= CHAR_UA && ch <= CHAR_UF));
         end
         if (i == cut_at) begin
            send_byte(CHAR_NUL);
            return;
         end
         send_byte(ch);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_plain_text();
      send_byte(8'h41);
      send_byte(8'hFE);
      send_byte(8'h01);
      send_byte(CHAR_QUOTE);
   endtask

   task automatic test_escapes();
      send_byte(CHAR_BACKSLASH);
      send_byte(CHAR_B);
      send_byte(CHAR_BACKSLASH);
      send_byte(CHAR_QUOTE);
      send_byte(CHAR_BACKSLASH);
      send_byte(8'hFF);
   endtask

   task automatic test_unicode();
      send_unicode(16'h07FF, 4, 4);
      // Quote and backslash among the digits are bad digits, not string syntax.
      send_byte(CHAR_BACKSLASH);
      send_byte(CHAR_U);
      send_byte(CHAR_UF);
      send_byte(CHAR_QUOTE);
      send_byte(CHAR_BACKSLASH);
      send_byte(CHAR_9);
   endtask

   task automatic test_zero_byte();
      send_byte(CHAR_BACKSLASH);
      send_byte(CHAR_NUL);
      send_unicode(16'h1234, 4, 1);
      send_byte(CHAR_NUL);
   endtask

   task automatic test_random_stream();
      logic [7:0]  b;
      logic [15:0] cp;
      while (bytes_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 29) == 0) send_idle = !send_idle;
         if ($urandom_range(0, 199) == 0) wait_for_results();
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
               do b = 8'($urandom_range(1, 255));
               while (b == CHAR_QUOTE || b == CHAR_BACKSLASH);
               send_byte(b);
            end
            7, 8, 9, 10, 11: begin
               case ($urandom_range(0, 8))
                  0: b = CHAR_B;
                  1: b = CHAR_F;
                  2: b = CHAR_N;
                  3: b = CHAR_R;
                  4: b = CHAR_T;
                  5: b = CHAR_QUOTE;
                  6: b = CHAR_BACKSLASH;
                  7: b = CHAR_SLASH;
                  default: begin
                     do b = 8'($urandom_range(1, 255));
                     while (b == CHAR_U);
                  end
               endcase
               send_byte(CHAR_BACKSLASH);
               send_byte(b);
            end
            12, 13, 14, 15, 16: begin
               case ($urandom_range(0, 5))
                  0: cp = 16'($urandom_range(0, 16'h007F));
                  1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                  2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                  3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                  4: begin
                     case ($urandom_range(0, 5))
                        0: cp = 16'h0000;
                        1: cp = 16'h007F;
                        2: cp = 16'h0080;
                        3: cp = 16'h07FF;
                        4: cp = 16'h0800;
                        default: cp = 16'hFFFF;
                     endcase
                  end
                  default: cp = 16'($urandom);
               endcase
               send_unicode(cp, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4, 4);
            end
            17: send_byte(CHAR_QUOTE);
            18: begin
               // Broken sequence: the string is cut by a zero byte mid-escape.
               if ($urandom_range(0, 1)) send_unicode(16'($urandom), 4, $urandom_range(0, 3));
               else begin
                  send_byte(CHAR_BACKSLASH);
                  send_byte(CHAR_NUL);
               end
            end
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // Result side: random stall before each beat, then check against the
   // oldest prediction.
   initial begin
      result_type want;
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
         stall = draw_wait(recv_idle);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (decoded_q.size() == 0) begin
            report_mismatch("result beat with no prediction waiting");
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte0 !== want.out_byte0)
               report_mismatch($sformatf("out_byte0 %h, want %h", rsp_out_byte0, want.out_byte0));
            if (rsp_out_byte1 !== want.out_byte1)
               report_mismatch($sformatf("out_byte1 %h, want %h", rsp_out_byte1, want.out_byte1));
            if (rsp_out_byte2 !== want.out_byte2)
               report_mismatch($sformatf("out_byte2 %h, want %h", rsp_out_byte2, want.out_byte2));
            if (rsp_out_count !== want.out_count)
               report_mismatch($sformatf("out_count %0d, want %0d", rsp_out_count, want.out_count));
            if (rsp_string_done !== want.string_done)
               report_mismatch($sformatf("string_done %b, want %b", rsp_string_done,
                                         want.string_done));
            if (rsp_error_flag !== want.error_flag)
               report_mismatch($sformatf("error_flag %b, want %b", rsp_error_flag,
                                         want.error_flag));
         end
         rsp_beats++;
      end
   end

   // Ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[json_string_unescape_utf8] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_plain_text();
      test_escapes();
      test_unicode();
      test_zero_byte();
      wait_for_results();
      test_random_stream();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && decoded_q.size() == 0) begin
         $display("[json_string_unescape_utf8] OK");
      end else begin
         $display("[json_string_unescape_utf8] ERROR");
      end
      $finish;
   end

endmodule

### files.f
hdl/jsu_pkg.sv
hdl/jsu_decode.sv
hdl/json_string_unescape_utf8.sv
tb/sv/tb_json_string_unescape_utf8.sv
